/* rtl/rdc_pkg.sv */
// Package for the radix digit converter: widths, limits and the digit-to-ASCII map.
`default_nettype none

package rdc_pkg;

    // Field and storage sizes
    localparam int VALUE_WIDTH  = 31;
    localparam int STACK_DEPTH  = 32;
    localparam int RADIX_WIDTH  = 5;
    localparam int DIGIT_WIDTH  = 5;
    localparam int CHAR_WIDTH   = 7;
    localparam int STACK_AW     = $clog2(STACK_DEPTH);
    localparam int COUNT_WIDTH  = $clog2(STACK_DEPTH + 1);
    localparam int BIT_CNT_W    = $clog2(VALUE_WIDTH);

    // Radix limits
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = RADIX_WIDTH'(27);

    // ASCII anchors
    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = CHAR_WIDTH'(48);
    localparam logic [CHAR_WIDTH-1:0] CHAR_LETTER = CHAR_WIDTH'(55);  // 'A' minus ten
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = DIGIT_WIDTH'(9);

    typedef logic [RADIX_WIDTH-1:0] radix_t;
    typedef logic [DIGIT_WIDTH-1:0] digit_t;

    // Clamp a written radix into the supported range
    function automatic radix_t clamp_radix(input radix_t r);
        radix_t res;
        res = r;
        if (r < RADIX_MIN) res = RADIX_MIN;
        if (r > RADIX_MAX) res = RADIX_MAX;
        return res;
    endfunction

    // '0'..'9' for values below ten, 'A' upward otherwise
    function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input digit_t v);
        logic [CHAR_WIDTH-1:0] res;
        if (v <= DIGIT_NINE)
            res = CHAR_ZERO + CHAR_WIDTH'(v);
        else
            res = CHAR_LETTER + CHAR_WIDTH'(v);
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/radix_digit_converter_core.sv */
// Radix converter: bit-serial repeated division, digit stack, MSD-first digit output.
//
//   channel   signals                                   handshake
//   -------   ----------------------------------------  -------------------------------
//   command   start, busy, value                        beat when start && !busy
//   result    strobe, digit_value, digit_char, last     beat on each strobe cycle
//   config    cfg_valid, cfg_ready, cfg_data            beat when cfg_valid && cfg_ready
//
// Each division runs one quotient bit per cycle through a shift register. A number
// with d digits goes through d divisions, then a stack read and a beat for each
// digit. The single-bit restoring-divide step sets the pace of each division.
// Reset sets radix to 2 and returns to idle. Results cannot be stalled; busy
// stays high until the beat carrying last has gone out.
`default_nettype none

module radix_digit_converter_core
    import rdc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // command
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [VALUE_WIDTH-1:0] value,
    // config
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [RADIX_WIDTH-1:0] cfg_data,
    // result
    output logic                        strobe,
    output logic [DIGIT_WIDTH-1:0]      digit_value,
    output logic [CHAR_WIDTH-1:0]       digit_char,
    output logic                        last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POP,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    radix_t                   radix_reg, radix_next;
    logic [VALUE_WIDTH-1:0]   quo_reg, quo_next;
    digit_t                   rem_reg, rem_next;
    logic [BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic                     last_reg, last_next;

    // digit stack
    digit_t                   stack_mem [STACK_DEPTH];
    digit_t                   rd_data_reg;
    logic                     push;
    logic [STACK_AW-1:0]      rd_addr;

    // divide step datapath
    logic [DIGIT_WIDTH:0]     rem_shift;
    logic                     rem_ge;
    logic [DIGIT_WIDTH:0]     rem_sub;
    digit_t                   rem_step;
    logic [VALUE_WIDTH-1:0]   quo_step;

    // One restoring-divide step: bring in the quotient MSB, subtract radix if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        rem_ge    = (rem_shift >= {1'b0, radix_reg});
        rem_sub   = rem_shift - {1'b0, radix_reg};
        rem_step  = rem_ge ? rem_sub[DIGIT_WIDTH-1:0] : rem_shift[DIGIT_WIDTH-1:0];
        quo_step  = {quo_reg[VALUE_WIDTH-2:0], rem_ge};
    end

    assign rd_addr = STACK_AW'(count_reg - COUNT_WIDTH'(1));

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        radix_next   = radix_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        push         = 1'b0;

        if (cfg_valid && cfg_ready)
            radix_next = clamp_radix(cfg_data);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    quo_next     = value;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    count_next   = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next     = quo_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1))
                begin
                    // division done: remainder is the next digit
                    if (count_reg < COUNT_WIDTH'(STACK_DEPTH))
                    begin
                        push       = 1'b1;
                        count_next = count_reg + COUNT_WIDTH'(1);
                    end
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    if (quo_step == '0)
                        state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                count_next = count_reg - COUNT_WIDTH'(1);
                last_next  = (count_reg == COUNT_WIDTH'(1));
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = last_reg ? ST_IDLE : ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_MIN;
            count_reg   <= '0;
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            radix_reg   <= radix_next;
            count_reg   <= count_next;
            bit_cnt_reg <= bit_cnt_next;
            last_reg    <= last_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Stack write on push, registered read on pop
    always_ff @(posedge clk)
    begin
        if (push)
            stack_mem[count_reg[STACK_AW-1:0]] <= rem_step;
        if (state_reg == ST_POP)
            rd_data_reg <= stack_mem[rd_addr];
    end

    // Ports
    assign busy        = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign strobe      = (state_reg == ST_EMIT);
    assign digit_value = rd_data_reg;
    assign digit_char  = digit_to_char(rd_data_reg);
    assign last        = last_reg;

    // Checks
    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");

    a_digit_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit_value < radix_reg))
        else $error("emitted digit not below radix");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !busy)
        else $error("still busy after last digit");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !strobe))
        else $error("accepted command did not start a division");

endmodule

`default_nettype wire
